[design/dge_pkg.sv]
// shared types and constants for the ducking gain envelope
`timescale 1ns / 1ps

package dge_pkg;

   localparam int PEAK_W      = 16;
   localparam int GAIN_W      = 24;
   localparam int BLOCKS_W    = 16;
   localparam int TICKS_W     = 32;
   localparam int TIME_W      = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam int QUEUE_DEPTH = 2;

   // magnitude of a gain step needs one bit above the gain width
   localparam int DIV_STEPS = GAIN_W + 1;

   // 0.05 dB in Q8.16, truncated
   localparam logic [GAIN_W:0] KEY_DIFF_LIMIT = 25'd3276;

   localparam logic signed [PEAK_W-1:0] THRESHOLD_RESET = -16'sd7680;
   localparam logic signed [GAIN_W-1:0] DEPTH_RESET     = -24'sd786432;
   localparam logic [BLOCKS_W-1:0]      ATTACK_RESET    = 16'd1;
   localparam logic [BLOCKS_W-1:0]      RELEASE_RESET   = 16'd4;
   localparam logic [TICKS_W-1:0]       BLOCK_TICKS_RESET = 32'd1024;
   localparam logic [TIME_W-1:0]        CLIP_TICKS_RESET  = 48'd48000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD   = 3'd0,
      CSR_DEPTH       = 3'd1,
      CSR_ATTACK      = 3'd2,
      CSR_RELEASE     = 3'd3,
      CSR_BLOCK_TICKS = 3'd4,
      CSR_CLIP_TICKS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [PEAK_W-1:0] threshold_db;
      logic signed [GAIN_W-1:0] duck_depth;
      logic [BLOCKS_W-1:0]      fall_blocks;
      logic [BLOCKS_W-1:0]      rel_blocks;
      logic [TICKS_W-1:0]       block_ticks;
      logic [TIME_W-1:0]        clip_ticks;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic ducked;
      logic last_block;
   } item_type;

endpackage

[design/ducking_gain_envelope.sv]
// top level of the ducking gain envelope: registers, front, queue and back
`timescale 1ns / 1ps

// Each item carries one dialogue block peak; the block answers with zero to three
// gain keyframes (time in clip ticks, gain in Q8.16 dB, closing flag). The front
// compares the peak with the threshold and parks the item in a short queue, so
// req_ready can stay high while the back end works on an earlier item, until the
// queue and the front's holding register fill. The back end picks each item up,
// runs the bit-serial divide of the envelope step, updates envelope and time, then
// visits each keyframe slot, waiting whenever the result side stalls. Items that
// arrive after the stream has stopped on time are taken and dropped. Write the
// registers only while no item is in flight; the block does not enforce this.

module ducking_gain_envelope #(
   parameter int QUEUE_DEPTH = dge_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [dge_pkg::PEAK_W-1:0]     req_peak_db,
   input  logic                                  req_last_block,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [dge_pkg::TIME_W-1:0]            rsp_key_time,
   output logic signed [dge_pkg::GAIN_W-1:0]     rsp_key_gain,
   output logic                                  rsp_final_key,
   input  logic                                  csr_wr_en,
   input  logic [dge_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [dge_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   dge_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push_valid;
   logic              push_ready;
   dge_pkg::item_type push_item;
   logic              head_valid;
   dge_pkg::item_type head_item;
   logic              pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dge_pkg::CSR_THRESHOLD:   cfg_in.threshold_db  = csr_wdata[dge_pkg::PEAK_W-1:0];
            dge_pkg::CSR_DEPTH:       cfg_in.duck_depth    = csr_wdata[dge_pkg::GAIN_W-1:0];
            dge_pkg::CSR_ATTACK:      cfg_in.fall_blocks   = csr_wdata[dge_pkg::BLOCKS_W-1:0];
            dge_pkg::CSR_RELEASE:     cfg_in.rel_blocks    = csr_wdata[dge_pkg::BLOCKS_W-1:0];
            dge_pkg::CSR_BLOCK_TICKS: cfg_in.block_ticks   = csr_wdata[dge_pkg::TICKS_W-1:0];
            dge_pkg::CSR_CLIP_TICKS:  cfg_in.clip_ticks    = csr_wdata[dge_pkg::TIME_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_db  <= dge_pkg::THRESHOLD_RESET;
         cfg_ff.duck_depth    <= dge_pkg::DEPTH_RESET;
         cfg_ff.fall_blocks   <= dge_pkg::ATTACK_RESET;
         cfg_ff.rel_blocks    <= dge_pkg::RELEASE_RESET;
         cfg_ff.block_ticks   <= dge_pkg::BLOCK_TICKS_RESET;
         cfg_ff.clip_ticks    <= dge_pkg::CLIP_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dge_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_peak_db    (req_peak_db),
      .req_last_block (req_last_block),
      .threshold_db   (cfg_ff.threshold_db),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_item      (push_item)
   );

   dge_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   dge_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_time  (rsp_key_time),
      .rsp_key_gain  (rsp_key_gain),
      .rsp_final_key (rsp_final_key)
   );

   // back end only takes an item that is really there
   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("item taken from empty queue");

   // closing keyframe sits at clip end
   a_final_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_final_key |-> rsp_key_time == cfg_ff.clip_ticks)
      else $error("closing keyframe not at clip end");

   // other keyframes never lie beyond clip end
   a_key_in_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_key |-> rsp_key_time <= cfg_ff.clip_ticks)
      else $error("keyframe beyond clip end");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

[design/dge_front.sv]
// front end: takes peak items, compares against the threshold and hands them on
`timescale 1ns / 1ps

module dge_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [dge_pkg::PEAK_W-1:0]  req_peak_db,
   input  logic                               req_last_block,
   input  logic signed [dge_pkg::PEAK_W-1:0]  threshold_db,
   output logic                               push_valid,
   input  logic                               push_ready,
   output dge_pkg::item_type                  push_item
);

   logic              hold_valid_ff, hold_valid_in;
   dge_pkg::item_type hold_item_ff, hold_item_in;
   logic              accept;
   logic              push;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push       = hold_valid_ff && push_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = hold_item_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (accept) begin
         hold_valid_in           = 1'b1;
         hold_item_in.ducked     = $signed(req_peak_db) >= $signed(threshold_db);
         hold_item_in.last_block = req_last_block;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

[design/dge_queue.sv]
// short item queue between front and back
`timescale 1ns / 1ps

module dge_queue #(
   parameter int DEPTH = dge_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dge_pkg::item_type push_item,
   output logic              head_valid,
   output dge_pkg::item_type head_item,
   input  logic              pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dge_pkg::item_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     push;
   logic                     take;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign take       = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !take) begin
         count_in = count_ff + 1'b1;
      end else if (take && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/dge_back.sv]
// back end: envelope step with serial divider, block time and keyframe output
`timescale 1ns / 1ps

module dge_back (
   input  logic                                clock,
   input  logic                                reset,
   input  dge_pkg::cfg_type                    cfg,
   input  logic                                head_valid,
   input  dge_pkg::item_type                   head_item,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dge_pkg::TIME_W-1:0]          rsp_key_time,
   output logic signed [dge_pkg::GAIN_W-1:0]   rsp_key_gain,
   output logic                                rsp_final_key
);

   localparam int GW    = dge_pkg::GAIN_W;
   localparam int TW    = dge_pkg::TIME_W;
   localparam int BW    = dge_pkg::BLOCKS_W;
   localparam int NSTEP = dge_pkg::DIV_STEPS;
   localparam int CW    = $clog2(NSTEP);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_UPD,
      ST_START,
      ST_CHANGE,
      ST_FINAL
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [GW:0]        dvd_ff, dvd_in;
   logic [BW-1:0]      rem_ff, rem_in;
   logic [BW-1:0]      div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [GW-1:0]      envelope_ff, envelope_in;
   logic [GW-1:0]      last_key_gain_ff, last_key_gain_in;
   logic [TW-1:0]      last_key_time_ff, last_key_time_in;
   logic [TW-1:0]      time_accum_ff, time_accum_in;
   logic [TW:0]        t_ff, t_in;
   logic               started_ff, started_in;
   logic               finished_ff, finished_in;
   logic               start_pend_ff, start_pend_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]      rsp_time_ff, rsp_time_in;
   logic [GW-1:0]      rsp_gain_ff, rsp_gain_in;
   logic               rsp_final_ff, rsp_final_in;

   logic [GW-1:0]      target;
   logic               falling;
   logic [BW-1:0]      div_sel;
   logic [GW:0]        diff;
   logic [GW:0]        diff_mag;
   logic [BW:0]        rem_shift;
   logic [BW:0]        rem_sub;
   logic               ge;
   logic [GW:0]        quot;
   logic [TW:0]        time_sum;
   logic               stop;
   logic [GW:0]        gdiff;
   logic [GW:0]        gdist;
   logic               change;
   logic               close_key;
   logic               out_free;

   // target and divisor from the head of the queue
   assign target   = head_item.ducked ? cfg.duck_depth : '0;
   assign falling  = $signed(target) < $signed(envelope_ff);
   assign div_sel  = falling ? cfg.fall_blocks : cfg.rel_blocks;
   assign diff     = {target[GW-1], target} - {envelope_ff[GW-1], envelope_ff};
   assign diff_mag = diff[GW] ? (~diff + 1'b1) : diff;

   // one quotient bit per cycle
   assign rem_shift = {rem_ff, dvd_ff[GW]};
   assign rem_sub   = rem_shift - {1'b0, div_ff};
   assign ge        = rem_shift >= {1'b0, div_ff};

   assign quot     = neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
   assign time_sum = {1'b0, time_accum_ff} + {{(TW + 1 - dge_pkg::TICKS_W){1'b0}},
                                              cfg.block_ticks};
   assign stop     = t_ff > {1'b0, cfg.clip_ticks};

   assign gdiff  = {envelope_ff[GW-1], envelope_ff} -
                   {last_key_gain_ff[GW-1], last_key_gain_ff};
   assign gdist  = gdiff[GW] ? (~gdiff + 1'b1) : gdiff;
   assign change = !stop && (gdist > dge_pkg::KEY_DIFF_LIMIT);

   assign close_key = (stop || last_ff) && (last_key_time_ff != cfg.clip_ticks);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_time  = rsp_time_ff;
   assign rsp_key_gain  = rsp_gain_ff;
   assign rsp_final_key = rsp_final_ff;

   always_comb begin
      state_in         = state_ff;
      cnt_in           = cnt_ff;
      dvd_in           = dvd_ff;
      rem_in           = rem_ff;
      div_in           = div_ff;
      neg_in           = neg_ff;
      envelope_in      = envelope_ff;
      last_key_gain_in = last_key_gain_ff;
      last_key_time_in = last_key_time_ff;
      time_accum_in    = time_accum_ff;
      t_in             = t_ff;
      started_in       = started_ff;
      finished_in      = finished_ff;
      start_pend_in    = start_pend_ff;
      last_in          = last_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_time_in      = rsp_time_ff;
      rsp_gain_in      = rsp_gain_ff;
      rsp_final_in     = rsp_final_ff;
      pop              = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (finished_ff) begin
                  // stream stopped on time: wait for the clip's last item
                  if (head_item.last_block) begin
                     envelope_in      = '0;
                     last_key_gain_in = '0;
                     last_key_time_in = '0;
                     time_accum_in    = '0;
                     started_in       = 1'b0;
                     finished_in      = 1'b0;
                  end
               end else begin
                  start_pend_in = !started_ff;
                  started_in    = 1'b1;
                  last_in       = head_item.last_block;
                  neg_in        = diff[GW];
                  dvd_in        = diff_mag;
                  rem_in        = '0;
                  cnt_in        = '0;
                  div_in        = (div_sel == '0) ? BW'(1) : div_sel;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            rem_in = ge ? rem_sub[BW-1:0] : rem_shift[BW-1:0];
            dvd_in = {dvd_ff[GW-1:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(NSTEP - 1)) begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            envelope_in   = envelope_ff + quot[GW-1:0];
            t_in          = time_sum;
            time_accum_in = time_sum[TW-1:0];
            state_in      = ST_START;
         end
         ST_START: begin
            if (!start_pend_ff) begin
               state_in = ST_CHANGE;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_time_in      = '0;
               rsp_gain_in      = '0;
               rsp_final_in     = 1'b0;
               last_key_time_in = '0;
               last_key_gain_in = '0;
               start_pend_in    = 1'b0;
               state_in         = ST_CHANGE;
            end
         end
         ST_CHANGE: begin
            if (!change) begin
               state_in = ST_FINAL;
            end else if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_time_in      = t_ff[TW-1:0];
               rsp_gain_in      = envelope_ff;
               rsp_final_in     = 1'b0;
               last_key_time_in = t_ff[TW-1:0];
               last_key_gain_in = envelope_ff;
               state_in         = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (!close_key || out_free) begin
               if (close_key) begin
                  rsp_valid_in     = 1'b1;
                  rsp_time_in      = cfg.clip_ticks;
                  rsp_gain_in      = envelope_ff;
                  rsp_final_in     = 1'b1;
                  last_key_time_in = cfg.clip_ticks;
                  last_key_gain_in = envelope_ff;
               end
               if (last_ff) begin
                  envelope_in      = '0;
                  last_key_gain_in = '0;
                  last_key_time_in = '0;
                  time_accum_in    = '0;
                  started_in       = 1'b0;
                  finished_in      = 1'b0;
               end else if (stop) begin
                  finished_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         envelope_ff      <= '0;
         last_key_gain_ff <= '0;
         last_key_time_ff <= '0;
         time_accum_ff    <= '0;
         started_ff       <= 1'b0;
         finished_ff      <= 1'b0;
         start_pend_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         envelope_ff      <= envelope_in;
         last_key_gain_ff <= last_key_gain_in;
         last_key_time_ff <= last_key_time_in;
         time_accum_ff    <= time_accum_in;
         started_ff       <= started_in;
         finished_ff      <= finished_in;
         start_pend_ff    <= start_pend_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cnt_ff       <= cnt_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      neg_ff       <= neg_in;
      t_ff         <= t_in;
      last_ff      <= last_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_gain_ff  <= rsp_gain_in;
      rsp_final_ff <= rsp_final_in;
   end

endmodule
